// ===== sv/chained_fixup_resolver_unit_assert.svh =====
// Assertion macros shared by the checker of the fixup resolver.
`ifndef CHAINED_FIXUP_RESOLVER_UNIT_ASSERT_SVH
`define CHAINED_FIXUP_RESOLVER_UNIT_ASSERT_SVH

// Overlapping implication, sampled on the rising clock edge, off during reset.
`define CRFR_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("crfr checker: property failed");

// Implication that starts checking in the cycle after the antecedent.
`define CRFR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("crfr checker: property failed");

`endif

// ===== sv/crfr_pkg.sv =====
package crfr_pkg;

  localparam int unsigned BIND_BIT       = 63;
  localparam int unsigned HIGH_SHIFT     = 56;
  localparam int unsigned NEXT_STRIDE_SH = 2;
  localparam int unsigned ORDINAL_W      = 24;
  localparam int unsigned TARGET_W       = 36;
  localparam int unsigned NEXT_LSB       = 51;
  localparam int unsigned NEXT_W         = 12;
  localparam int unsigned ENTRY_IDX_W    = 10;
  localparam int unsigned STRIDE_W       = 13;
  localparam int unsigned COUNT_W        = 11;
  localparam int unsigned STUB_OFF_W     = 25;
  localparam int unsigned CFG_IDX_W      = 3;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_RESOLVE = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT_IS_OFFSET = 3'd0,
    REG_PREFERRED_BASE   = 3'd1,
    REG_LOAD_SLIDE       = 3'd2,
    REG_STUB_REGION_BASE = 3'd3,
    REG_STUB_STRIDE      = 3'd4,
    REG_IMPORT_COUNT     = 3'd5,
    REG_MAPPED_LOW       = 3'd6,
    REG_MAPPED_HIGH      = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic                format_is_offset;
    logic [63:0]         preferred_base;
    logic [63:0]         load_slide;
    logic [63:0]         stub_region_base;
    logic [STRIDE_W-1:0] stub_stride;
    logic [COUNT_W-1:0]  import_count;
    logic [63:0]         mapped_low;
    logic [63:0]         mapped_high;
  } cfg_t;

  // One import table entry as kept in the memory.
  typedef struct packed {
    logic [63:0] native;
    logic        present;
    logic        is_code;
  } entry_t;

  // Everything the resolve stage needs of one decoded fixup word.
  typedef struct packed {
    logic                  out_of_window;
    logic                  is_bind;
    logic                  ordinal_ok;
    logic [ORDINAL_W-1:0]  ordinal;
    logic [7:0]            addend;
    logic [STUB_OFF_W-1:0] stub_offset;
    logic [63:0]           rebase_base;
    logic [TARGET_W-1:0]   target;
    logic [7:0]            high_byte;
    logic                  next_zero;
    logic [63:0]           next_address;
    logic [63:0]           raw_word;
    logic [63:0]           word_address;
  } dec_t;

endpackage

// ===== sv/crfr_import_ram.sv =====
module crfr_import_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  crfr_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output crfr_pkg::entry_t rdata_o
);
  import crfr_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/crfr_decode.sv =====
module crfr_decode #(
  parameter int unsigned IMPORT_DEPTH = 1024,
  parameter int unsigned AW           = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           resolve_i,
  input  logic [63:0]    word_address_i,
  input  logic [63:0]    raw_word_i,
  input  crfr_pkg::cfg_t cfg_i,
  output logic           rd_en_o,
  output logic [AW-1:0]  rd_addr_o,
  output logic           dec_valid_o,
  output crfr_pkg::dec_t dec_o
);
  import crfr_pkg::*;

  localparam logic [ORDINAL_W:0] DepthLimit = (ORDINAL_W + 1)'(IMPORT_DEPTH);

  logic [NEXT_W-1:0]    next_field;
  logic [ORDINAL_W-1:0] ordinal;
  logic [7:0]           addend;
  logic [23:0]          stub_prod;
  logic                 valid_q;
  dec_t                 dec_d;
  dec_t                 dec_q;

  assign next_field = raw_word_i[NEXT_LSB +: NEXT_W];
  assign ordinal    = raw_word_i[ORDINAL_W-1:0];
  assign addend     = raw_word_i[31:24];

  // A valid ordinal is below the import count, so eleven bits suffice here.
  assign stub_prod = 24'(ordinal[COUNT_W-1:0]) * 24'(cfg_i.stub_stride);

  always_comb begin
    dec_d = '0;
    dec_d.out_of_window = (word_address_i < cfg_i.mapped_low) ||
                          (word_address_i > cfg_i.mapped_high);
    dec_d.is_bind       = raw_word_i[BIND_BIT];
    dec_d.ordinal_ok    = (ordinal < ORDINAL_W'(cfg_i.import_count)) &&
                          ({1'b0, ordinal} < DepthLimit);
    dec_d.ordinal       = ordinal;
    dec_d.addend        = addend;
    dec_d.stub_offset   = STUB_OFF_W'(stub_prod) + STUB_OFF_W'(addend);
    dec_d.rebase_base   = cfg_i.format_is_offset ?
                          (cfg_i.preferred_base + cfg_i.load_slide) : cfg_i.load_slide;
    dec_d.target        = raw_word_i[TARGET_W-1:0];
    dec_d.high_byte     = raw_word_i[TARGET_W +: 8];
    dec_d.next_zero     = (next_field == '0);
    dec_d.next_address  = word_address_i +
                          64'({next_field, {NEXT_STRIDE_SH{1'b0}}});
    dec_d.raw_word      = raw_word_i;
    dec_d.word_address  = word_address_i;
  end

  assign rd_en_o   = resolve_i;
  assign rd_addr_o = AW'(ordinal);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= resolve_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resolve_i) begin
      dec_q <= dec_d;
    end
  end

  assign dec_valid_o = valid_q;
  assign dec_o       = dec_q;

endmodule

// ===== sv/crfr_resolve.sv =====
module crfr_resolve (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             dec_valid_i,
  input  crfr_pkg::dec_t   dec_i,
  input  crfr_pkg::entry_t entry_i,
  input  logic [63:0]      stub_region_base_i,
  output logic             result_valid_o,
  output logic [63:0]      fixed_word_o,
  output logic [63:0]      next_address_o,
  output logic             chain_end_o,
  output logic             out_of_window_o,
  output logic             was_bind_o,
  output logic [23:0]      bound_ordinal_o,
  output logic             ordinal_valid_o
);
  import crfr_pkg::*;

  logic [63:0] native_sum;
  logic [63:0] stub_sum;
  logic [63:0] rebase_sum;
  logic [63:0] fixed_d;
  logic        bind_ok;

  logic        valid_q;
  logic [63:0] fixed_q;
  logic [63:0] next_q;
  logic        chain_end_q;
  logic        oow_q;
  logic        bind_q;
  logic [23:0] ordinal_q;
  logic        ordinal_valid_q;

  assign native_sum = entry_i.native + 64'(dec_i.addend);
  assign stub_sum   = stub_region_base_i + 64'(dec_i.stub_offset);
  assign rebase_sum = dec_i.rebase_base + 64'(dec_i.target);
  assign bind_ok    = !dec_i.out_of_window && dec_i.is_bind;

  always_comb begin
    if (dec_i.out_of_window) begin
      fixed_d = dec_i.raw_word;
    end else if (dec_i.is_bind) begin
      if (!dec_i.ordinal_ok) begin
        fixed_d = '0;
      end else if (entry_i.present && !entry_i.is_code) begin
        fixed_d = native_sum;
      end else begin
        fixed_d = stub_sum;
      end
    end else begin
      fixed_d = rebase_sum | {dec_i.high_byte, {HIGH_SHIFT{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dec_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_valid_i) begin
      fixed_q         <= fixed_d;
      next_q          <= dec_i.out_of_window ? dec_i.word_address : dec_i.next_address;
      chain_end_q     <= dec_i.out_of_window || dec_i.next_zero;
      oow_q           <= dec_i.out_of_window;
      bind_q          <= bind_ok;
      ordinal_q       <= bind_ok ? dec_i.ordinal : '0;
      ordinal_valid_q <= bind_ok && dec_i.ordinal_ok;
    end
  end

  assign result_valid_o  = valid_q;
  assign fixed_word_o    = fixed_q;
  assign next_address_o  = next_q;
  assign chain_end_o     = chain_end_q;
  assign out_of_window_o = oow_q;
  assign was_bind_o      = bind_q;
  assign bound_ordinal_o = ordinal_q;
  assign ordinal_valid_o = ordinal_valid_q;

endmodule

// ===== sv/chained_fixup_resolver_unit.sv =====
// Resolves 64-bit chained-fixup words against an import table held in one
// synchronous memory. The block takes an item in every cycle: busy is never
// raised, and each resolve gives its result on the result ports for one cycle,
// marked by result_valid_o, after passing the decode register and the resolve
// register; a load gives no result. The resolve reads the entry at the edge
// that takes the beat and the next stage combines the entry with the decoded
// word. A load writes its entry at the edge that takes it, so a resolve in the
// very next cycle already sees it. The receiver cannot stall.
module chained_fixup_resolver_unit #(
  parameter int unsigned IMPORT_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [63:0] word_address_i,
  input  logic [63:0] raw_word_i,
  input  logic [9:0]  entry_index_i,
  input  logic [63:0] entry_native_i,
  input  logic        entry_present_i,
  input  logic        entry_is_code_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [63:0] fixed_word_o,
  output logic [63:0] next_address_o,
  output logic        chain_end_o,
  output logic        out_of_window_o,
  output logic        was_bind_o,
  output logic [23:0] bound_ordinal_o,
  output logic        ordinal_valid_o
);
  import crfr_pkg::*;

  localparam int unsigned AW = (IMPORT_DEPTH > 1) ? $clog2(IMPORT_DEPTH) : 1;
  localparam logic [ORDINAL_W:0] DepthLimit = (ORDINAL_W + 1)'(IMPORT_DEPTH);
  localparam cfg_t CfgReset = '{stub_stride: STRIDE_W'(16), default: '0};

  cfg_t    cfg_q;
  logic    accept;
  logic    resolve;
  logic    load_we;
  entry_t  wr_entry;
  entry_t  rd_entry;
  logic    rd_en;
  logic [AW-1:0] rd_addr;
  logic    dec_valid;
  dec_t    dec;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign resolve = accept && (op_e'(operation_i) == OP_RESOLVE);
  assign load_we = accept && (op_e'(operation_i) == OP_LOAD) &&
                   ((ORDINAL_W + 1)'(entry_index_i) < DepthLimit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FORMAT_IS_OFFSET: cfg_q.format_is_offset <= cfg_data_i[0];
        REG_PREFERRED_BASE:   cfg_q.preferred_base   <= cfg_data_i;
        REG_LOAD_SLIDE:       cfg_q.load_slide       <= cfg_data_i;
        REG_STUB_REGION_BASE: cfg_q.stub_region_base <= cfg_data_i;
        REG_STUB_STRIDE:      cfg_q.stub_stride      <= cfg_data_i[STRIDE_W-1:0];
        REG_IMPORT_COUNT:     cfg_q.import_count     <= cfg_data_i[COUNT_W-1:0];
        REG_MAPPED_LOW:       cfg_q.mapped_low       <= cfg_data_i;
        REG_MAPPED_HIGH:      cfg_q.mapped_high      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign wr_entry.native  = entry_native_i;
  assign wr_entry.present = entry_present_i;
  assign wr_entry.is_code = entry_is_code_i;

  crfr_import_ram #(
    .DEPTH (IMPORT_DEPTH),
    .AW    (AW)
  ) u_import_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  crfr_decode #(
    .IMPORT_DEPTH (IMPORT_DEPTH),
    .AW           (AW)
  ) u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .resolve_i      (resolve),
    .word_address_i (word_address_i),
    .raw_word_i     (raw_word_i),
    .cfg_i          (cfg_q),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .dec_valid_o    (dec_valid),
    .dec_o          (dec)
  );

  crfr_resolve u_resolve (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .dec_valid_i        (dec_valid),
    .dec_i              (dec),
    .entry_i            (rd_entry),
    .stub_region_base_i (cfg_q.stub_region_base),
    .result_valid_o     (result_valid_o),
    .fixed_word_o       (fixed_word_o),
    .next_address_o     (next_address_o),
    .chain_end_o        (chain_end_o),
    .out_of_window_o    (out_of_window_o),
    .was_bind_o         (was_bind_o),
    .bound_ordinal_o    (bound_ordinal_o),
    .ordinal_valid_o    (ordinal_valid_o)
  );

endmodule

// ===== sv/crfr_checker.sv =====
`include "chained_fixup_resolver_unit_assert.svh"

module crfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        operation_i,
  input logic [63:0] word_address_i,
  input logic        result_valid_o,
  input logic [63:0] next_address_o,
  input logic        chain_end_o,
  input logic        out_of_window_o,
  input logic        was_bind_o,
  input logic [23:0] bound_ordinal_o,
  input logic        ordinal_valid_o
);
  import crfr_pkg::*;

  logic resolve_beat;
  logic res_miss;
  logic ord_clear;
  logic miss_clear;

  assign resolve_beat = start && !busy && (op_e'(operation_i) == OP_RESOLVE);
  assign res_miss     = result_valid_o && out_of_window_o;
  assign ord_clear    = !ordinal_valid_o && (bound_ordinal_o == '0);
  assign miss_clear   = chain_end_o && !was_bind_o && ord_clear;

  // Every resolve beat gives exactly one result, and every result comes from a resolve beat.
  `CRFR_ASSERT_NEXT(a_resolve_gives_result, clk_i, rst_ni, resolve_beat, ##1 result_valid_o)
  `CRFR_ASSERT_IMP(a_result_from_resolve, clk_i, rst_ni, result_valid_o, $past(resolve_beat, 2))
  // A window miss ends the chain in place and reports no bind.
  `CRFR_ASSERT_IMP(a_window_miss, clk_i, rst_ni, res_miss, miss_clear)
  `CRFR_ASSERT_IMP(a_miss_next, clk_i, rst_ni, res_miss, next_address_o == $past(word_address_i, 2))
  `CRFR_ASSERT_IMP(a_rebase_no_ordinal, clk_i, rst_ni, result_valid_o && !was_bind_o, ord_clear)

endmodule

bind chained_fixup_resolver_unit crfr_checker u_crfr_checker (.*);

// ===== tb/chained_fixup_resolver_unit_tb.sv =====
`timescale 1ns / 1ps

module chained_fixup_resolver_unit_tb;
  import crfr_pkg::*;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    op_e         op;
    logic [63:0] word_address;
    logic [63:0] raw_word;
    logic [9:0]  entry_index;
    logic [63:0] entry_native;
    logic        entry_present;
    logic        entry_is_code;
  } beat_t;

  typedef struct packed {
    logic [63:0] fixed_word;
    logic [63:0] next_address;
    logic        chain_end;
    logic        out_of_window;
    logic        was_bind;
    logic [23:0] bound_ordinal;
    logic        ordinal_valid;
  } fix_t;

  // Holds a private copy of the registers and the import table, and the queue
  // of fixed words still owed by the block.
  class fixup_tracker;
    cfg_t        regs;
    logic [63:0] native_tbl [TABLE_DEPTH];
    logic [1:0]  kind_tbl [TABLE_DEPTH];
    fix_t        owed_fixes [$];
    int          mismatches;

    function new();
      regs = '0;
      regs.stub_stride = 13'd16;
      mismatches = 0;
      foreach (native_tbl[i]) begin
        native_tbl[i] = '0;
        kind_tbl[i] = '0;
      end
    endfunction

    function void set_reg(cfg_reg_e r, logic [63:0] v);
      case (r)
        REG_FORMAT_IS_OFFSET: regs.format_is_offset = v[0];
        REG_PREFERRED_BASE:   regs.preferred_base = v;
        REG_LOAD_SLIDE:       regs.load_slide = v;
        REG_STUB_REGION_BASE: regs.stub_region_base = v;
        REG_STUB_STRIDE:      regs.stub_stride = v[STRIDE_W-1:0];
        REG_IMPORT_COUNT:     regs.import_count = v[COUNT_W-1:0];
        REG_MAPPED_LOW:       regs.mapped_low = v;
        REG_MAPPED_HIGH:      regs.mapped_high = v;
        default: ;
      endcase
    endfunction

    function fix_t resolve(beat_t b);
      fix_t        f;
      logic [11:0] nxt;
      logic [23:0] ord;
      logic [7:0]  addend;
      logic [63:0] slid;
      f = '0;
      if (b.word_address < regs.mapped_low || b.word_address > regs.mapped_high) begin
        f.fixed_word = b.raw_word;
        f.next_address = b.word_address;
        f.chain_end = 1'b1;
        f.out_of_window = 1'b1;
        return f;
      end
      nxt = b.raw_word[NEXT_LSB +: NEXT_W];
      f.next_address = b.word_address + (64'(nxt) << NEXT_STRIDE_SH);
      f.chain_end = (nxt == 12'd0);
      if (b.raw_word[BIND_BIT]) begin
        ord = b.raw_word[23:0];
        addend = b.raw_word[31:24];
        f.was_bind = 1'b1;
        f.bound_ordinal = ord;
        if (ord < regs.import_count && ord < TABLE_DEPTH) begin
          f.ordinal_valid = 1'b1;
          // Only a present data import is bound directly; the rest go to a stub.
          if (kind_tbl[ord[9:0]] == 2'b01)
            f.fixed_word = native_tbl[ord[9:0]] + 64'(addend);
          else
            f.fixed_word = regs.stub_region_base + 64'(ord) * 64'(regs.stub_stride)
                           + 64'(addend);
        end
      end else begin
        if (regs.format_is_offset)
          slid = regs.preferred_base + regs.load_slide + 64'(b.raw_word[35:0]);
        else
          slid = 64'(b.raw_word[35:0]) + regs.load_slide;
        f.fixed_word = slid | (64'(b.raw_word[43:36]) << HIGH_SHIFT);
      end
      return f;
    endfunction

    function void take_beat(beat_t b);
      if (b.op == OP_LOAD) begin
        native_tbl[b.entry_index] = b.entry_native;
        kind_tbl[b.entry_index] = {b.entry_is_code, b.entry_present};
      end else begin
        owed_fixes.push_back(resolve(b));
      end
    endfunction

    function void cmp(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_fix(fix_t got);
      fix_t want;
      if (owed_fixes.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = owed_fixes.pop_front();
      cmp("fixed_word", want.fixed_word, got.fixed_word);
      cmp("next_address", want.next_address, got.next_address);
      cmp("chain_end", 64'(want.chain_end), 64'(got.chain_end));
      cmp("out_of_window", 64'(want.out_of_window), 64'(got.out_of_window));
      cmp("was_bind", 64'(want.was_bind), 64'(got.was_bind));
      cmp("bound_ordinal", 64'(want.bound_ordinal), 64'(got.bound_ordinal));
      cmp("ordinal_valid", 64'(want.ordinal_valid), 64'(got.ordinal_valid));
    endfunction

    function int pending();
      return owed_fixes.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  beat_t       beat_q;
  logic        cfg_we;
  cfg_reg_e    cfg_index;
  logic [63:0] cfg_data;
  fix_t        fix_out;
  logic        result_valid;

  fixup_tracker sb;
  int unsigned  stall_cycles;

  // Generator side view of the configuration and of the table.
  cfg_t        cur_cfg;
  bit          written [TABLE_DEPTH];
  int unsigned written_list [$];
  bit          chain_live;
  logic [63:0] chain_addr;

  chained_fixup_resolver_unit #(
    .IMPORT_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (beat_q.op),
    .word_address_i (beat_q.word_address),
    .raw_word_i     (beat_q.raw_word),
    .entry_index_i  (beat_q.entry_index),
    .entry_native_i (beat_q.entry_native),
    .entry_present_i(beat_q.entry_present),
    .entry_is_code_i(beat_q.entry_is_code),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .result_valid_o (result_valid),
    .fixed_word_o   (fix_out.fixed_word),
    .next_address_o (fix_out.next_address),
    .chain_end_o    (fix_out.chain_end),
    .out_of_window_o(fix_out.out_of_window),
    .was_bind_o     (fix_out.was_bind),
    .bound_ordinal_o(fix_out.bound_ordinal),
    .ordinal_valid_o(fix_out.ordinal_valid)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid)
        sb.check_fix(fix_out);
      if (cfg_we)
        sb.set_reg(cfg_index, cfg_data);
      if (start && !busy)
        sb.take_beat(beat_q);
      if (result_valid || cfg_we || (start && !busy))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk_i); while (stall_cycles < STALL_LIMIT);
    $display("chained_fixup_resolver_unit test failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] bind_word(logic [11:0] nxt, logic [7:0] addend,
                                            logic [23:0] ord);
    return {1'b1, nxt, 19'($urandom), addend, ord};
  endfunction

  function automatic logic [63:0] rebase_word(logic [11:0] nxt, logic [7:0] hib,
                                              logic [35:0] target);
    return {1'b0, nxt, 7'($urandom), hib, target};
  endfunction

  function automatic beat_t load_beat(logic [9:0] idx, logic [63:0] native,
                                      logic present, logic is_code);
    beat_t b;
    b.op = OP_LOAD;
    b.word_address = rand64();
    b.raw_word = rand64();
    b.entry_index = idx;
    b.entry_native = native;
    b.entry_present = present;
    b.entry_is_code = is_code;
    return b;
  endfunction

  function automatic beat_t resolve_beat(logic [63:0] addr, logic [63:0] raw);
    beat_t b;
    b.op = OP_RESOLVE;
    b.word_address = addr;
    b.raw_word = raw;
    b.entry_index = 10'($urandom);
    b.entry_native = rand64();
    b.entry_present = 1'($urandom);
    b.entry_is_code = 1'($urandom);
    return b;
  endfunction

  // Builds the next resolve beat. Most beats follow the chain of the previous
  // word; bind ordinals below the import count are only taken from loaded slots.
  function automatic beat_t next_resolve();
    logic [63:0] addr;
    logic [63:0] span;
    logic [63:0] raw;
    logic [63:0] target;
    logic [11:0] nxt;
    logic [23:0] ord;
    int unsigned r;
    bit          found;
    r = $urandom_range(99);
    span = cur_cfg.mapped_high - cur_cfg.mapped_low;
    if (chain_live && r < 85)
      addr = chain_addr;
    else begin
      r = $urandom_range(99);
      if (r < 70) begin
        if (cur_cfg.mapped_low > cur_cfg.mapped_high || span == '1)
          addr = rand64();
        else
          addr = cur_cfg.mapped_low + rand64() % (span + 64'd1);
      end else if (r < 78) addr = cur_cfg.mapped_low;
      else if (r < 86) addr = cur_cfg.mapped_high;
      else if (r < 90) addr = cur_cfg.mapped_low - 64'd1;
      else if (r < 94) addr = cur_cfg.mapped_high + 64'd1;
      else addr = rand64();
    end
    r = $urandom_range(99);
    nxt = (r < 15) ? 12'd0 : (r < 20) ? 12'hFFF : 12'($urandom);
    if ($urandom_range(1)) begin
      r = $urandom_range(99);
      found = 1'b0;
      ord = '0;
      if (r < 65 && written_list.size() > 0) begin
        for (int t = 0; t < 8 && !found; t++) begin
          ord = 24'(written_list[$urandom_range(written_list.size() - 1)]);
          found = (ord < cur_cfg.import_count);
        end
      end
      if (!found) begin
        if (r < 80) ord = 24'(cur_cfg.import_count) + 24'($urandom_range(40));
        else if (r < 88) ord = 24'hFFFFFF;
        else ord = 24'($urandom);
        if (ord < cur_cfg.import_count && !written[ord[9:0]])
          ord = 24'(cur_cfg.import_count);
      end
      raw = bind_word(nxt, 8'($urandom), ord);
    end else begin
      r = $urandom_range(99);
      target = (r < 15) ? 64'hF_FFFF_FFFF : (r < 30) ? 64'd0 : rand64();
      raw = rebase_word(nxt, 8'($urandom), target[35:0]);
    end
    chain_live = nxt != 12'd0 && addr >= cur_cfg.mapped_low && addr <= cur_cfg.mapped_high;
    chain_addr = addr + (64'(nxt) << NEXT_STRIDE_SH);
    return resolve_beat(addr, raw);
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.format_is_offset = 1'($urandom);
    c.preferred_base = rand64();
    c.load_slide = rand64();
    c.stub_region_base = rand64();
    c.stub_stride = 13'($urandom_range(4096, 1));
    c.import_count = 11'($urandom_range(1024));
    if ($urandom_range(1)) begin
      c.mapped_low = '0;
      c.mapped_high = '1;
    end else begin
      c.mapped_low = rand64() & 64'h0000_FFFF_FFFF_FFFF;
      c.mapped_high = c.mapped_low + (rand64() & 64'h0000_0FFF_FFFF_FFFF);
    end
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(beat_t b);
    if (b.op == OP_LOAD && !written[b.entry_index]) begin
      written[b.entry_index] = 1'b1;
      written_list.push_back(b.entry_index);
    end
    beat_q <= b;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic pause(int unsigned n);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Waits until every owed result is checked, then idles further; loads give no result beat.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(negedge clk_i);
  endtask

  task automatic program_regs(cfg_t c);
    drain();
    write_reg(REG_FORMAT_IS_OFFSET, 64'(c.format_is_offset));
    write_reg(REG_PREFERRED_BASE, c.preferred_base);
    write_reg(REG_LOAD_SLIDE, c.load_slide);
    write_reg(REG_STUB_REGION_BASE, c.stub_region_base);
    write_reg(REG_STUB_STRIDE, 64'(c.stub_stride));
    write_reg(REG_IMPORT_COUNT, 64'(c.import_count));
    write_reg(REG_MAPPED_LOW, c.mapped_low);
    write_reg(REG_MAPPED_HIGH, c.mapped_high);
    cfg_we <= 1'b0;
    cur_cfg = c;
    chain_live = 1'b0;
  endtask

  task automatic run_phase(int unsigned beats, bit idle_on);
    for (int unsigned n = 0; n < beats; n++) begin
      // Idling comes in alternating stretches of forty beats.
      if (idle_on && ((n / 40) % 2 == 0) && $urandom_range(5) == 0)
        pause($urandom_range(13, 1));
      if ($urandom_range(3) == 0)
        send_beat(load_beat(10'($urandom),
                            ($urandom_range(9) == 0) ? '1 :
                            ($urandom_range(9) == 0) ? '0 : rand64(),
                            1'($urandom), 1'($urandom)));
      else
        send_beat(next_resolve());
    end
  endtask

  initial begin
    cfg_t c;
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    beat_q = '0;
    cfg_we = 1'b0;
    cfg_index = REG_FORMAT_IS_OFFSET;
    cfg_data = '0;
    stall_cycles = 0;
    chain_live = 1'b0;
    chain_addr = '0;
    cur_cfg = sb.regs;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: wide window with a few imports, then the extremes.
    c.format_is_offset = 1'b0;
    c.preferred_base = 64'h0000_0001_0000_0000;
    c.load_slide = 64'h0000_0000_4000_0000;
    c.stub_region_base = 64'h0000_0000_7000_0000;
    c.stub_stride = 13'd16;
    c.import_count = 11'd8;
    c.mapped_low = 64'h0000_0000_0000_1000;
    c.mapped_high = 64'hFFFF_FFFF_FFFF_F000;
    program_regs(c);
    send_beat(load_beat(10'd0, '1, 1'b1, 1'b0));
    send_beat(load_beat(10'd1, rand64(), 1'b1, 1'b1));
    send_beat(load_beat(10'd2, rand64(), 1'b0, 1'b0));
    send_beat(load_beat(10'd3, rand64(), 1'b0, 1'b1));
    send_beat(load_beat(10'd7, '0, 1'b1, 1'b0));
    send_beat(load_beat(10'd1023, rand64(), 1'b1, 1'b0));
    send_beat(resolve_beat(c.mapped_low, bind_word(12'd1, 8'hFF, 24'd0)));
    send_beat(resolve_beat(c.mapped_high, bind_word(12'hFFF, 8'h00, 24'd1)));
    send_beat(resolve_beat(64'h0000_0000_0010_0000, bind_word(12'd5, 8'h3C, 24'd2)));
    send_beat(resolve_beat(64'h0000_0000_0010_0008, bind_word(12'd0, 8'hFF, 24'd3)));
    send_beat(resolve_beat(64'h0000_0000_0010_0010, bind_word(12'd2, 8'h01, 24'd7)));
    send_beat(resolve_beat(64'h0000_0000_0010_0018, bind_word(12'd2, 8'h01, 24'd8)));
    send_beat(resolve_beat(64'h0000_0000_0010_0020, bind_word(12'd2, 8'hFF, 24'hFFFFFF)));
    send_beat(resolve_beat(64'h0000_0000_0010_0028,
                           rebase_word(12'hFFF, 8'hFF, 36'hF_FFFF_FFFF)));
    send_beat(resolve_beat(64'h0000_0000_0010_0030, rebase_word(12'd0, 8'h00, 36'd0)));
    send_beat(resolve_beat(c.mapped_low - 64'd1, bind_word(12'd3, 8'h10, 24'd0)));
    send_beat(resolve_beat('1, rebase_word(12'd3, 8'h80, 36'h1234)));
    send_beat(resolve_beat('0, bind_word(12'd0, 8'h00, 24'd1)));

    c.format_is_offset = 1'b1;
    c.preferred_base = '1;
    c.load_slide = '1;
    c.stub_region_base = '1;
    c.stub_stride = 13'd4096;
    c.import_count = 11'd1024;
    c.mapped_low = '0;
    c.mapped_high = '1;
    program_regs(c);
    send_beat(resolve_beat(64'h8000_0000_0000_0000,
                           rebase_word(12'd1, 8'hFF, 36'hF_FFFF_FFFF)));
    send_beat(resolve_beat('1, rebase_word(12'hFFF, 8'h00, 36'd0)));
    send_beat(resolve_beat('0, bind_word(12'd7, 8'h22, 24'd1023)));
    send_beat(resolve_beat(64'h0000_0000_0000_0040, bind_word(12'd1, 8'h00, 24'd1)));
    send_beat(resolve_beat(64'h0000_0000_0000_0044, bind_word(12'd1, 8'h00, 24'd1024)));
    send_beat(resolve_beat(64'h0000_0000_0000_0048, bind_word(12'd0, 8'hFF, 24'd3)));

    // Random part under a sequence of settings.
    program_regs(random_cfg());
    run_phase(190, 1'b1);

    c = random_cfg();
    c.format_is_offset = 1'b0;
    c.load_slide = '0;
    c.stub_stride = 13'd1;
    c.import_count = 11'd0;
    program_regs(c);
    run_phase(190, 1'b1);

    c = random_cfg();
    c.format_is_offset = 1'b1;
    c.preferred_base = '1;
    c.load_slide = '1;
    c.stub_region_base = '1;
    c.stub_stride = 13'd4096;
    c.import_count = 11'd1024;
    c.mapped_low = '0;
    c.mapped_high = '1;
    program_regs(c);
    run_phase(190, 1'b1);

    // A single mapped address, then an empty (inverted) window.
    c = random_cfg();
    c.mapped_high = c.mapped_low;
    program_regs(c);
    run_phase(190, 1'b1);

    c = random_cfg();
    c.mapped_low = 64'h0000_8000_0000_0000;
    c.mapped_high = 64'h0000_7FFF_FFFF_FFFF;
    program_regs(c);
    run_phase(190, 1'b1);

    program_regs(random_cfg());
    run_phase(190, 1'b0);

    drain();
    repeat (8) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("chained_fixup_resolver_unit test passed");
    else
      $display("chained_fixup_resolver_unit test failed");
    $finish;
  end

endmodule
